// File: sv/fxq_pkg.sv
// Package for the Q24.8 fixed-point ALU: widths, opcodes and the result record.
// Used by every module of the block; depends on nothing.
package fxq_pkg;

   localparam int FRAC_BITS = 8;
   localparam int WORD_W    = 32;
   localparam int NUM_W     = WORD_W + FRAC_BITS;
   localparam int WIDE_W    = NUM_W + 2;
   localparam int PROD_W    = 2 * WORD_W;

   typedef enum logic [3:0] {
      KIND_ADD      = 4'd0,
      KIND_SUB      = 4'd1,
      KIND_MUL      = 4'd2,
      KIND_DIV      = 4'd3,
      KIND_EQ       = 4'd4,
      KIND_NE       = 4'd5,
      KIND_LT       = 4'd6,
      KIND_LE       = 4'd7,
      KIND_GT       = 4'd8,
      KIND_GE       = 4'd9,
      KIND_MIN      = 4'd10,
      KIND_MAX      = 4'd11,
      KIND_INC      = 4'd12,
      KIND_DEC      = 4'd13,
      KIND_FROM_INT = 4'd14,
      KIND_TO_INT   = 4'd15
   } kind_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              cmp;
      logic              ovf;
      logic              dz;
   } res_type;

   function automatic logic [WORD_W-1:0] mag_word(input logic [WORD_W-1:0] v);
      return v[WORD_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic res_type sat_word(input logic [WIDE_W-1:0] v);
      res_type r;
      r.cmp = 1'b0;
      r.dz  = 1'b0;
      r.ovf = !((&v[WIDE_W-1:WORD_W-1]) || !(|v[WIDE_W-1:WORD_W-1]));
      if (r.ovf) begin
         r.value = v[WIDE_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
         r.value = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: sv/fxq_mul.sv
// Two-stage signed fixed-point multiplier with rounding and saturation.
// Depends on fxq_pkg.
module fxq_mul
   import fxq_pkg::*;
(
   input  logic              clock,
   input  logic [WORD_W-1:0] a,
   input  logic [WORD_W-1:0] b,
   output res_type           res
);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              neg_ff, neg_in;
   res_type           res_ff, res_in;
   logic [PROD_W-1:0] q;
   logic [PROD_W-1:0] limit;

   always_comb begin
      prod_in = PROD_W'(mag_word(a)) * PROD_W'(mag_word(b));
      neg_in  = a[WORD_W-1] ^ b[WORD_W-1];
   end

   always_comb begin
      q      = (prod_ff + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      limit  = (PROD_W'(1) << (WORD_W - 1)) - PROD_W'(!neg_ff);
      res_in.cmp = 1'b0;
      res_in.dz  = 1'b0;
      res_in.ovf = q > limit;
      if (res_in.ovf) begin
         res_in.value = neg_ff ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
         res_in.value = neg_ff ? (~q[WORD_W-1:0] + 1'b1) : q[WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   assign res = res_ff;

endmodule

// File: sv/fxq_div.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding and saturation.
// Depends on fxq_pkg.
module fxq_div
   import fxq_pkg::*;
(
   input  logic              clock,
   input  logic [WORD_W-1:0] a,
   input  logic [WORD_W-1:0] b,
   output res_type           res
);

   logic [WORD_W-1:0] rem_ff [NUM_W:1];
   logic [NUM_W-1:0]  nq_ff  [NUM_W:1];
   logic [WORD_W-1:0] den_ff [NUM_W:1];
   logic              neg_ff [NUM_W:1];
   logic              dz_ff  [NUM_W:1];

   logic [WORD_W-1:0] rem_in [NUM_W:1];
   logic [NUM_W-1:0]  nq_in  [NUM_W:1];
   logic [WORD_W-1:0] den_in [NUM_W:1];
   logic              neg_in [NUM_W:1];
   logic              dz_in  [NUM_W:1];

   logic [WORD_W-1:0] rem_src [NUM_W:1];
   logic [NUM_W-1:0]  nq_src  [NUM_W:1];

   res_type           res_ff, res_in;
   logic [NUM_W:0]    q;
   logic [WIDE_W-1:0] sv;

   for (genvar k = 1; k <= NUM_W; k++) begin : g_step
      logic [WORD_W:0] t;
      if (k == 1) begin : g_first
         assign rem_src[k] = '0;
         assign nq_src[k]  = {mag_word(a), {FRAC_BITS{1'b0}}};
         assign den_in[k]  = mag_word(b);
         assign neg_in[k]  = a[WORD_W-1] ^ b[WORD_W-1];
         assign dz_in[k]   = !(|b);
      end else begin : g_next
         assign rem_src[k] = rem_ff[k-1];
         assign nq_src[k]  = nq_ff[k-1];
         assign den_in[k]  = den_ff[k-1];
         assign neg_in[k]  = neg_ff[k-1];
         assign dz_in[k]   = dz_ff[k-1];
      end
      always_comb begin
         t = {rem_src[k], nq_src[k][NUM_W-1]};
         if (t >= {1'b0, den_in[k]}) begin
            rem_in[k] = WORD_W'(t - {1'b0, den_in[k]});
            nq_in[k]  = {nq_src[k][NUM_W-2:0], 1'b1};
         end else begin
            rem_in[k] = t[WORD_W-1:0];
            nq_in[k]  = {nq_src[k][NUM_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in[k];
         nq_ff[k]  <= nq_in[k];
         den_ff[k] <= den_in[k];
         neg_ff[k] <= neg_in[k];
         dz_ff[k]  <= dz_in[k];
      end
   end

   always_comb begin
      q  = {1'b0, nq_ff[NUM_W]}
         + (NUM_W+1)'({rem_ff[NUM_W], 1'b0} >= {1'b0, den_ff[NUM_W]});
      sv = neg_ff[NUM_W] ? (~{1'b0, q} + 1'b1) : {1'b0, q};
      if (dz_ff[NUM_W]) begin
         res_in = '0;
         res_in.dz = 1'b1;
      end else begin
         res_in = sat_word(sv);
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

// File: sv/fixed_point_q24_8_alu_top.sv
// Top level of the Q24.8 fixed-point ALU: input register, simple operations,
// alignment lines and result register. Depends on fxq_pkg, fxq_mul and fxq_div.
//
// A transaction is accepted at a rising edge with start high and busy low.
// busy is held low: the block takes one transaction in every cycle.
// Each transaction carries an opcode and two raw Q24.8 operands and yields
// exactly one result, shown on the rsp_ ports for one cycle with rsp_valid
// high, in the order the transactions were accepted.
// The latency runs through the input register, the divider's quotient stages
// and output register, and the result register. It is set by the divider, which resolves
// one quotient bit per pipeline stage; all other operations are delayed to
// match, so every opcode sees the same latency.
// Throughput is one transaction per cycle for every opcode mix.
// Reset clears the valid bits of all stages; transactions in flight are
// dropped and no result appears until new transactions arrive.
// The receiver cannot stall, so no backpressure exists inside the pipeline.
module fixed_point_q24_8_alu_top
   import fxq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [3:0]               req_kind,
   input  logic signed [WORD_W-1:0] req_operand_a,
   input  logic signed [WORD_W-1:0] req_operand_b,
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] rsp_result_value,
   output logic                     rsp_compare_true,
   output logic                     rsp_overflow,
   output logic                     rsp_divide_by_zero
);

   localparam int D   = NUM_W + 1;
   localparam int LAT = D + 2;

   logic              vld_ff  [D:0];
   kind_type          kind_ff [D:0];
   res_type           simple_ff [D:1];
   res_type           mul_ff  [D:3];
   logic [WORD_W-1:0] a_ff, b_ff;

   res_type           simple_in;
   res_type           mul_res, div_res;
   res_type           out_in, out_ff;
   logic              out_vld_ff;
   logic              accept;
   logic signed [WORD_W-1:0] sa, sb;
   logic [WORD_W:0]   to_int_sum;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign sa     = $signed(a_ff);
   assign sb     = $signed(b_ff);

   always_comb begin
      simple_in  = '0;
      to_int_sum = {a_ff[WORD_W-1], a_ff}
                 + {{(WORD_W+1-FRAC_BITS){1'b0}}, {FRAC_BITS{a_ff[WORD_W-1]}}};
      case (kind_ff[0])
         KIND_ADD: simple_in = sat_word(WIDE_W'(sa) + WIDE_W'(sb));
         KIND_SUB: simple_in = sat_word(WIDE_W'(sa) - WIDE_W'(sb));
         KIND_EQ:  simple_in.cmp = sa == sb;
         KIND_NE:  simple_in.cmp = sa != sb;
         KIND_LT:  simple_in.cmp = sa < sb;
         KIND_LE:  simple_in.cmp = sa <= sb;
         KIND_GT:  simple_in.cmp = sa > sb;
         KIND_GE:  simple_in.cmp = sa >= sb;
         KIND_MIN: simple_in.value = (sb < sa) ? b_ff : a_ff;
         KIND_MAX: simple_in.value = (sa < sb) ? b_ff : a_ff;
         KIND_INC: simple_in = sat_word(WIDE_W'(sa) + WIDE_W'(1));
         KIND_DEC: simple_in = sat_word(WIDE_W'(sa) - WIDE_W'(1));
         KIND_FROM_INT: begin
            simple_in = sat_word({{(WIDE_W-WORD_W-FRAC_BITS){a_ff[WORD_W-1]}}, a_ff,
                                  {FRAC_BITS{1'b0}}});
         end
         KIND_TO_INT: simple_in.value = WORD_W'($signed(to_int_sum) >>> FRAC_BITS);
         default: simple_in = '0;
      endcase
   end

   fxq_mul u_mul (
      .clock (clock),
      .a     (a_ff),
      .b     (b_ff),
      .res   (mul_res)
   );

   fxq_div u_div (
      .clock (clock),
      .a     (a_ff),
      .b     (b_ff),
      .res   (div_res)
   );

   always_comb begin
      case (kind_ff[D])
         KIND_MUL: out_in = mul_ff[D];
         KIND_DIV: out_in = div_res;
         default:  out_in = simple_ff[D];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= D; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int k = 1; k <= D; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         out_vld_ff <= vld_ff[D];
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= req_operand_a;
      b_ff       <= req_operand_b;
      kind_ff[0] <= kind_type'(req_kind);
      for (int k = 1; k <= D; k++) begin
         kind_ff[k] <= kind_ff[k-1];
      end
      simple_ff[1] <= simple_in;
      for (int k = 2; k <= D; k++) begin
         simple_ff[k] <= simple_ff[k-1];
      end
      mul_ff[3] <= mul_res;
      for (int k = 4; k <= D; k++) begin
         mul_ff[k] <= mul_ff[k-1];
      end
      out_ff <= out_in;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_result_value   = $signed(out_ff.value);
   assign rsp_compare_true   = out_ff.cmp;
   assign rsp_overflow       = out_ff.ovf;
   assign rsp_divide_by_zero = out_ff.dz;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("Result did not appear after the pipeline latency.");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_result_value == 0 && !rsp_overflow)
      else $error("Divide by zero gave a nonzero result or overflow.");

   a_cmp_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> rsp_result_value == 0 && !rsp_overflow
         && !rsp_divide_by_zero)
      else $error("Comparison result carries other outcome bits.");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_divide_by_zero)
      else $error("Overflow and divide by zero flagged together.");

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the Q24.8 fixed-point ALU: drives opcode and operand transactions,
// predicts each result with exact integer arithmetic and checks it field by field.
// Depends on fxq_pkg and fixed_point_q24_8_alu_top.
module tb_top
   import fxq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      kind_type          kind;
      logic signed [31:0] a;
      logic signed [31:0] b;
   } alu_op_type;

   typedef struct {
      logic signed [31:0] value;
      logic               cmp;
      logic               ovf;
      logic               dz;
   } alu_res_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [3:0]               req_kind = '0;
   logic signed [31:0]       req_operand_a = '0;
   logic signed [31:0]       req_operand_b = '0;
   logic                     rsp_valid;
   logic signed [31:0]       rsp_result_value;
   logic                     rsp_compare_true;
   logic                     rsp_overflow;
   logic                     rsp_divide_by_zero;

   alu_op_type  pending_ops[$];
   alu_res_type expected_results[$];
   int          mismatches = 0;
   int          idle_left = 0;
   bit          stimulus_done = 1'b0;

   fixed_point_q24_8_alu_top dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic alu_res_type saturate(input longint v);
      alu_res_type r;
      r = '{0, 1'b0, 1'b0, 1'b0};
      if (v > 64'sd2147483647) begin
         r.value = 32'h7fffffff;
         r.ovf = 1'b1;
      end else if (v < -64'sd2147483648) begin
         r.value = 32'h80000000;
         r.ovf = 1'b1;
      end else begin
         r.value = v[31:0];
      end
      return r;
   endfunction

   function automatic alu_res_type predict_alu(input alu_op_type op);
      alu_res_type r;
      longint a, b, ma, mb, q, rem, num;
      bit neg;
      a = op.a;
      b = op.b;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      neg = (a < 0) != (b < 0);
      r = '{0, 1'b0, 1'b0, 1'b0};
      case (op.kind)
         KIND_ADD: r = saturate(a + b);
         KIND_SUB: r = saturate(a - b);
         KIND_MUL: begin
            q = (ma * mb + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            r = saturate(neg ? -q : q);
         end
         KIND_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
            end else begin
               num = ma <<< FRAC_BITS;
               q = num / mb;
               rem = num % mb;
               if (rem >= mb - rem) q = q + 1;
               r = saturate(neg ? -q : q);
            end
         end
         KIND_EQ: r.cmp = (a == b);
         KIND_NE: r.cmp = (a != b);
         KIND_LT: r.cmp = (a < b);
         KIND_LE: r.cmp = (a <= b);
         KIND_GT: r.cmp = (a > b);
         KIND_GE: r.cmp = (a >= b);
         KIND_MIN: r.value = (b < a) ? op.b : op.a;
         KIND_MAX: r.value = (a < b) ? op.b : op.a;
         KIND_INC: r = saturate(a + 1);
         KIND_DEC: r = saturate(a - 1);
         KIND_FROM_INT: r = saturate(a * (64'sd1 <<< FRAC_BITS));
         default: begin
            q = a / (64'sd1 <<< FRAC_BITS);
            r.value = q[31:0];
         end
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff - $urandom_range(0, 3);
         1: return 32'h80000000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 4) - 2;
         3, 4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         5: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic int rand_gap();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic queue_op(input kind_type k, input logic [31:0] a, input logic [31:0] b);
      alu_op_type op;
      op.kind = k;
      op.a = a;
      op.b = b;
      pending_ops.push_back(op);
   endtask

   // Driver: a transaction goes out when the idle count runs out.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else if (idle_left > 0) begin
         idle_left <= idle_left - 1;
         start <= 1'b0;
      end else if (pending_ops.size() > 0) begin
         alu_op_type op;
         op = pending_ops.pop_front();
         req_kind <= op.kind;
         req_operand_a <= op.a;
         req_operand_b <= op.b;
         expected_results.push_back(predict_alu(op));
         start <= 1'b1;
         idle_left <= rand_gap();
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: every strobed result is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         alu_res_type exp_r;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result value=%h", $time, rsp_result_value);
            mismatches <= mismatches + 1;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_result_value !== exp_r.value || rsp_compare_true !== exp_r.cmp ||
                rsp_overflow !== exp_r.ovf || rsp_divide_by_zero !== exp_r.dz) begin
               $display("%0t: mismatch expected value=%h cmp=%b ovf=%b dz=%b",
                        $time, exp_r.value, exp_r.cmp, exp_r.ovf, exp_r.dz);
               $display("%0t:          actual   value=%h cmp=%b ovf=%b dz=%b",
                        $time, rsp_result_value, rsp_compare_true, rsp_overflow,
                        rsp_divide_by_zero);
               mismatches <= mismatches + 1;
            end
         end
      end
   end

   initial begin
      kind_type k;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 16; i++) begin
         k = kind_type'(i);
         queue_op(k, 32'h7fffffff, 32'h80000000);
      end
      queue_op(KIND_DIV, 32'h00000100, 32'h00000000);
      queue_op(KIND_DIV, 32'h00000001, 32'h00000002);
      queue_op(KIND_DIV, 32'hffffffff, 32'h00000200);
      queue_op(KIND_MUL, 32'h00000080, 32'h00000001);
      queue_op(KIND_MUL, 32'hffffff80, 32'h00000001);
      queue_op(KIND_MIN, 32'h00000005, 32'h00000005);
      queue_op(KIND_INC, 32'h80000000, 32'hffffffff);
      queue_op(KIND_DEC, 32'h7fffffff, 32'h00000000);
      queue_op(KIND_TO_INT, 32'hffffff01, 32'h00000000);
      for (int i = 0; i < 1300; i++) begin
         k = kind_type'($urandom_range(0, 15));
         queue_op(k, rand_operand(), rand_operand());
      end
      wait (pending_ops.size() == 0 && expected_results.size() == 0);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("PASS fixed_point_q24_8_alu_top");
      end else begin
         $display("FAIL fixed_point_q24_8_alu_top");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL fixed_point_q24_8_alu_top");
      $finish;
   end
endmodule
